/* hdl/bale_pkg.sv */
package bale_pkg;

    // Command codes carried in the cmd field
    typedef enum logic [3:0] {
        CMD_APPEND  = 4'd0,
        CMD_POP     = 4'd1,
        CMD_READ    = 4'd2,
        CMD_WRITE   = 4'd3,
        CMD_INSERT  = 4'd4,
        CMD_DELAT   = 4'd5,
        CMD_FIND    = 4'd6,
        CMD_DELVAL  = 4'd7,
        CMD_REPLACE = 4'd8,
        CMD_DEDUP   = 4'd9,
        CMD_SORT    = 4'd10,
        CMD_CLEAR   = 4'd11
    } cmd_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned LEN_W  = 7;

    typedef struct packed {
        logic [3:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [LEN_W-1:0]         list_length;
    } out_item_t;

    // Micro-operations issued by the controller to the datapath
    typedef enum logic [5:0] {
        OP_NONE,
        OP_LOAD,
        OP_FAIL,
        OP_APPEND,
        OP_POP,
        OP_RD_POS,
        OP_CAP_RD,
        OP_WR_POS,
        OP_INS_INIT,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_DEL_INIT,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_DEL_END,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_SET_FPOS,
        OP_REPL,
        OP_DD_INIT,
        OP_DD_RD,
        OP_DD_HOLD,
        OP_DD_SCAN,
        OP_DD_SKIP,
        OP_DD_KNEXT,
        OP_DD_KEEP,
        OP_DD_END,
        OP_SRT_INIT,
        OP_SRT_PASS,
        OP_SRT_LOAD,
        OP_SRT_CMP,
        OP_SRT_END,
        OP_CLEAR,
        OP_EMIT
    } dp_op_t;

    // Conditions reported by the datapath
    typedef struct packed {
        logic [3:0] cmd;
        logic       full;
        logic       empty;
        logic       pos_lt_cnt;
        logic       pos_le_cnt;
        logic       i_gt_pos;
        logic       del_more;
        logic       i_lt_cnt;
        logic       k_lt_j;
        logic       j_zero;
        logic       cnt_le1;
        logic       rd_eq_val;
        logic       rd_eq_hold;
        logic       last_step;
        logic       out_free;
    } dp_status_t;

endpackage

/* hdl/bale_ram.sv */
module bale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/bale_datapath.sv */
module bale_datapath #(
    parameter int unsigned LIST_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bale_pkg::in_item_t   in_data,
    input  bale_pkg::dp_op_t     op,
    output bale_pkg::dp_status_t status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output bale_pkg::out_item_t  out_data
);

    import bale_pkg::*;

    localparam int unsigned AW = $clog2(LIST_DEPTH);
    localparam int unsigned IW = $clog2(LIST_DEPTH + 1);

    logic [3:0]        cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] nval_reg;
    logic [IW-1:0]     count_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     j_reg;
    logic [IW-1:0]     k_reg;
    logic [DATA_W-1:0] hold_reg;
    logic              fail_reg;
    logic [DATA_W-1:0] rdv_reg;
    logic [POS_W-1:0]  fpos_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic              swap;

    bale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign swap = $signed(hold_reg) > $signed(rdata);

    // Report conditions to the controller
    always_comb
    begin
        status.cmd        = cmd_reg;
        status.full       = (count_reg == IW'(LIST_DEPTH));
        status.empty      = (count_reg == '0);
        status.pos_lt_cnt = (32'(pos_reg) < 32'(count_reg));
        status.pos_le_cnt = (32'(pos_reg) <= 32'(count_reg));
        status.i_gt_pos   = (32'(i_reg) > 32'(pos_reg));
        status.del_more   = ((32'(i_reg) + 32'd1) < 32'(count_reg));
        status.i_lt_cnt   = (i_reg < count_reg);
        status.k_lt_j     = (k_reg < j_reg);
        status.j_zero     = (j_reg == '0);
        status.cnt_le1    = (32'(count_reg) <= 32'd1);
        status.rd_eq_val  = (rdata == val_reg);
        status.rd_eq_hold = (rdata == hold_reg);
        status.last_step  = ((32'(i_reg) + 32'd1) == 32'(j_reg));
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Select memory write and read addresses
    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(i_reg);
        wdata = hold_reg;
        raddr = '0;
        case (op)
            OP_APPEND:
            begin
                we    = 1'b1;
                waddr = AW'(count_reg);
                wdata = val_reg;
            end
            OP_WR_POS, OP_INS_PUT:
            begin
                we    = 1'b1;
                waddr = AW'(pos_reg);
                wdata = val_reg;
            end
            OP_INS_WR, OP_DEL_WR:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            OP_REPL:
            begin
                we    = 1'b1;
                wdata = nval_reg;
            end
            OP_DD_KEEP:
            begin
                we    = 1'b1;
                waddr = AW'(j_reg);
            end
            OP_SRT_CMP:
            begin
                we    = 1'b1;
                wdata = swap ? rdata : hold_reg;
                raddr = AW'(i_reg + IW'(2));
            end
            OP_SRT_END:
            begin
                we    = 1'b1;
            end
            OP_RD_POS:  raddr = AW'(pos_reg);
            OP_INS_RD:  raddr = AW'(i_reg - IW'(1));
            OP_DEL_RD:  raddr = AW'(i_reg + IW'(1));
            OP_SCAN_RD: raddr = AW'(i_reg);
            OP_DD_RD:   raddr = AW'(i_reg);
            OP_DD_SCAN: raddr = AW'(k_reg);
            OP_SRT_LOAD: raddr = AW'(i_reg + IW'(1));
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Advance counters, hold registers and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            nval_reg      <= '0;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            hold_reg      <= '0;
            fail_reg      <= 1'b0;
            rdv_reg       <= '0;
            fpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_LOAD:
                begin
                    cmd_reg  <= in_data.cmd;
                    pos_reg  <= in_data.position;
                    val_reg  <= in_data.value;
                    nval_reg <= in_data.new_value;
                    fail_reg <= 1'b0;
                    rdv_reg  <= '0;
                    fpos_reg <= '0;
                end
                OP_FAIL:      fail_reg  <= 1'b1;
                OP_APPEND:    count_reg <= count_reg + IW'(1);
                OP_POP:       count_reg <= count_reg - IW'(1);
                OP_CAP_RD:    rdv_reg   <= rdata;
                OP_INS_INIT:  i_reg     <= count_reg;
                OP_INS_WR:    i_reg     <= i_reg - IW'(1);
                OP_INS_PUT:   count_reg <= count_reg + IW'(1);
                OP_DEL_INIT:  i_reg     <= IW'(pos_reg);
                OP_DEL_WR:    i_reg     <= i_reg + IW'(1);
                OP_DEL_END:   count_reg <= count_reg - IW'(1);
                OP_SCAN_INIT: i_reg     <= '0;
                OP_SCAN_NEXT: i_reg     <= i_reg + IW'(1);
                OP_SET_FPOS:  fpos_reg  <= POS_W'(i_reg);
                OP_DD_INIT:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                OP_DD_HOLD:
                begin
                    hold_reg <= rdata;
                    k_reg    <= '0;
                end
                OP_DD_SKIP:   i_reg <= i_reg + IW'(1);
                OP_DD_KNEXT:  k_reg <= k_reg + IW'(1);
                OP_DD_KEEP:
                begin
                    j_reg <= j_reg + IW'(1);
                    i_reg <= i_reg + IW'(1);
                end
                OP_DD_END:    count_reg <= j_reg;
                OP_SRT_INIT:  j_reg     <= count_reg - IW'(1);
                OP_SRT_PASS:  i_reg     <= '0;
                OP_SRT_LOAD:  hold_reg  <= rdata;
                OP_SRT_CMP:
                begin
                    if (!swap)
                    begin
                        hold_reg <= rdata;
                    end
                    i_reg <= i_reg + IW'(1);
                end
                OP_SRT_END:   j_reg     <= j_reg - IW'(1);
                OP_CLEAR:     count_reg <= '0;
                OP_EMIT:
                begin
                    out_valid_reg               <= 1'b1;
                    out_data_reg.status         <= fail_reg;
                    out_data_reg.read_value     <= rdv_reg;
                    out_data_reg.found_position <= fpos_reg;
                    out_data_reg.list_length    <= LEN_W'(count_reg);
                end
                default:
                begin
                    fail_reg <= fail_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/bale_ctrl.sv */
module bale_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bale_pkg::dp_status_t status,
    output bale_pkg::dp_op_t     op
);

    import bale_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE     = 18'd1 << 0,
        S_DECODE   = 18'd1 << 1,
        S_RD_WAIT  = 18'd1 << 2,
        S_INS_RD   = 18'd1 << 3,
        S_INS_WR   = 18'd1 << 4,
        S_DEL_RD   = 18'd1 << 5,
        S_DEL_WR   = 18'd1 << 6,
        S_SCAN_RD  = 18'd1 << 7,
        S_SCAN_CMP = 18'd1 << 8,
        S_DD_RD    = 18'd1 << 9,
        S_DD_HOLD  = 18'd1 << 10,
        S_DD_SCAN  = 18'd1 << 11,
        S_DD_CMP   = 18'd1 << 12,
        S_SRT_PASS = 18'd1 << 13,
        S_SRT_LOAD = 18'd1 << 14,
        S_SRT_CMP  = 18'd1 << 15,
        S_SRT_END  = 18'd1 << 16,
        S_FIN      = 18'd1 << 17
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Pick the micro-operation and the next state
    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                case (status.cmd)
                    CMD_APPEND:  op = status.full ? OP_FAIL : OP_APPEND;
                    CMD_POP:     op = status.empty ? OP_FAIL : OP_POP;
                    CMD_WRITE:   op = status.pos_lt_cnt ? OP_WR_POS : OP_FAIL;
                    CMD_CLEAR:   op = OP_CLEAR;
                    CMD_READ:
                    begin
                        if (status.pos_lt_cnt)
                        begin
                            op         = OP_RD_POS;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            op = OP_FAIL;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (!status.full && status.pos_le_cnt)
                        begin
                            op         = OP_INS_INIT;
                            state_next = S_INS_RD;
                        end
                        else
                        begin
                            op = OP_FAIL;
                        end
                    end
                    CMD_DELAT:
                    begin
                        if (status.pos_lt_cnt)
                        begin
                            op         = OP_DEL_INIT;
                            state_next = S_DEL_RD;
                        end
                        else
                        begin
                            op = OP_FAIL;
                        end
                    end
                    CMD_FIND, CMD_DELVAL, CMD_REPLACE:
                    begin
                        op         = OP_SCAN_INIT;
                        state_next = S_SCAN_RD;
                    end
                    CMD_DEDUP:
                    begin
                        op         = OP_DD_INIT;
                        state_next = S_DD_RD;
                    end
                    CMD_SORT:
                    begin
                        if (!status.cnt_le1)
                        begin
                            op         = OP_SRT_INIT;
                            state_next = S_SRT_PASS;
                        end
                    end
                    default:     op = OP_FAIL;
                endcase
            end
            S_RD_WAIT:
            begin
                op         = OP_CAP_RD;
                state_next = S_FIN;
            end
            // Shift the tail up one entry at a time, top first
            S_INS_RD:
            begin
                if (status.i_gt_pos)
                begin
                    op         = OP_INS_RD;
                    state_next = S_INS_WR;
                end
                else
                begin
                    op         = OP_INS_PUT;
                    state_next = S_FIN;
                end
            end
            S_INS_WR:
            begin
                op         = OP_INS_WR;
                state_next = S_INS_RD;
            end
            // Shift the tail down one entry at a time
            S_DEL_RD:
            begin
                if (status.del_more)
                begin
                    op         = OP_DEL_RD;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    op         = OP_DEL_END;
                    state_next = S_FIN;
                end
            end
            S_DEL_WR:
            begin
                op         = OP_DEL_WR;
                state_next = S_DEL_RD;
            end
            // Walk the list for the first match
            S_SCAN_RD:
            begin
                if (status.i_lt_cnt)
                begin
                    op         = OP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    op         = OP_FAIL;
                    state_next = S_FIN;
                end
            end
            S_SCAN_CMP:
            begin
                if (status.rd_eq_val)
                begin
                    case (status.cmd)
                        CMD_FIND:
                        begin
                            op         = OP_SET_FPOS;
                            state_next = S_FIN;
                        end
                        CMD_REPLACE:
                        begin
                            op         = OP_REPL;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_DEL_RD;
                        end
                    endcase
                end
                else
                begin
                    op         = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            // Compact: keep an entry only if it is not already kept
            S_DD_RD:
            begin
                if (status.i_lt_cnt)
                begin
                    op         = OP_DD_RD;
                    state_next = S_DD_HOLD;
                end
                else
                begin
                    op         = OP_DD_END;
                    state_next = S_FIN;
                end
            end
            S_DD_HOLD:
            begin
                op         = OP_DD_HOLD;
                state_next = S_DD_SCAN;
            end
            S_DD_SCAN:
            begin
                if (status.k_lt_j)
                begin
                    op         = OP_DD_SCAN;
                    state_next = S_DD_CMP;
                end
                else
                begin
                    op         = OP_DD_KEEP;
                    state_next = S_DD_RD;
                end
            end
            S_DD_CMP:
            begin
                if (status.rd_eq_hold)
                begin
                    op         = OP_DD_SKIP;
                    state_next = S_DD_RD;
                end
                else
                begin
                    op         = OP_DD_KNEXT;
                    state_next = S_DD_SCAN;
                end
            end
            // Bubble passes carrying the running maximum
            S_SRT_PASS:
            begin
                if (status.j_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    op         = OP_SRT_PASS;
                    state_next = S_SRT_LOAD;
                end
            end
            S_SRT_LOAD:
            begin
                op         = OP_SRT_LOAD;
                state_next = S_SRT_CMP;
            end
            S_SRT_CMP:
            begin
                op         = OP_SRT_CMP;
                state_next = status.last_step ? S_SRT_END : S_SRT_CMP;
            end
            S_SRT_END:
            begin
                op         = OP_SRT_END;
                state_next = S_SRT_PASS;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/bounded_array_list_engine.sv */
// Bounded list of signed 32-bit values held in a single-port-write RAM.
// Commands enter on the in channel (in_valid/in_ready, one in_item_t per
// transaction); each command returns exactly one out_item_t on the out
// channel (out_valid/out_ready) with status, read value, found position
// and the list length after the command.
// One command is processed at a time. Insert and delete at shift the
// tail one entry at a time; find, replace and delete value scan from the
// front for the first match; dedup compacts the list, keeping an entry
// only if it is not already kept; sort runs bubble passes. The RAM has
// one read port, with a registered read.
// A new command is taken once the previous result sits in the output
// register; if out_ready stays low, the next result waits and input stalls.
// Reset clears the length to zero; RAM contents are not cleared.
module bounded_array_list_engine #(
    parameter int unsigned LIST_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bale_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bale_pkg::out_item_t out_data
);

    import bale_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    bale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    bale_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .op        (op),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

/* tb/bounded_array_list_engine_tb.sv */
module bounded_array_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bale_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 200000;

    int unsigned mismatch_count = 0;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // Shadow list and queue of predicted results
    class list_scoreboard;
        logic [31:0] shadow_vals[DEPTH];
        int          shadow_len;
        out_item_t   pending[$];

        function new();
            shadow_len = 0;
            foreach (shadow_vals[i]) shadow_vals[i] = '0;
        endfunction

        function int first_index(logic [31:0] v);
            for (int i = 0; i < shadow_len; i++)
                if (shadow_vals[i] == v) return i;
            return shadow_len;
        endfunction

        function void drop_at(int idx);
            for (int i = idx; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i + 1];
            shadow_len--;
        endfunction

        // Apply one command to the shadow list and queue its result
        function void note_command(in_item_t c);
            out_item_t r;
            int p;
            int m;
            int j;
            logic [31:0] t;
            r = '0;
            p = c.position;
            case (c.cmd)
                CMD_APPEND:
                    if (shadow_len >= DEPTH) r.status = 1'b1;
                    else begin shadow_vals[shadow_len] = c.value; shadow_len++; end
                CMD_POP:
                    if (shadow_len == 0) r.status = 1'b1;
                    else shadow_len--;
                CMD_READ:
                    if (p >= shadow_len) r.status = 1'b1;
                    else r.read_value = shadow_vals[p];
                CMD_WRITE:
                    if (p >= shadow_len) r.status = 1'b1;
                    else shadow_vals[p] = c.value;
                CMD_INSERT:
                    if (shadow_len >= DEPTH || p > shadow_len) r.status = 1'b1;
                    else begin
                        for (int i = shadow_len; i > p; i--) shadow_vals[i] = shadow_vals[i - 1];
                        shadow_vals[p] = c.value;
                        shadow_len++;
                    end
                CMD_DELAT:
                    if (p >= shadow_len) r.status = 1'b1;
                    else drop_at(p);
                CMD_FIND: begin
                    m = first_index(c.value);
                    if (m >= shadow_len) r.status = 1'b1;
                    else r.found_position = m[5:0];
                end
                CMD_DELVAL: begin
                    m = first_index(c.value);
                    if (m >= shadow_len) r.status = 1'b1;
                    else drop_at(m);
                end
                CMD_REPLACE: begin
                    m = first_index(c.value);
                    if (m >= shadow_len) r.status = 1'b1;
                    else shadow_vals[m] = c.new_value;
                end
                CMD_DEDUP:
                    for (int i = 0; i < shadow_len; i++) begin
                        j = i + 1;
                        while (j < shadow_len)
                            if (shadow_vals[j] == shadow_vals[i]) drop_at(j);
                            else j++;
                    end
                CMD_SORT:
                    for (int i = 1; i < shadow_len; i++)
                        for (int k = 0; k + i < shadow_len; k++)
                            if ($signed(shadow_vals[k]) > $signed(shadow_vals[k + 1])) begin
                                t = shadow_vals[k];
                                shadow_vals[k] = shadow_vals[k + 1];
                                shadow_vals[k + 1] = t;
                            end
                CMD_CLEAR: shadow_len = 0;
                default: r.status = 1'b1;
            endcase
            r.list_length = shadow_len[6:0];
            pending.push_back(r);
        endfunction

        // Compare one result with the oldest prediction
        task check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0) begin
                report_mismatch("result with no command outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report_mismatch($sformatf("status got %0b exp %0b", got.status, e.status));
            if (got.read_value !== e.read_value)
                report_mismatch($sformatf("read_value got %0h exp %0h",
                                          got.read_value, e.read_value));
            if (got.found_position !== e.found_position)
                report_mismatch($sformatf("found_position got %0d exp %0d",
                                          got.found_position, e.found_position));
            if (got.list_length !== e.list_length)
                report_mismatch($sformatf("list_length got %0d exp %0d",
                                          got.list_length, e.list_length));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    list_scoreboard sb = new();
    bit  quiet_phase = 1'b0;
    int  idle_cycles = 0;
    int  sent_count = 0;
    int  got_count = 0;
    int  fail_cmds = 0;

    always #5 clk = ~clk;

    bounded_array_list_engine #(.LIST_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Check every result transaction and end the run if nothing moves
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            got_count++;
            if (out_data.status) fail_cmds++;
            sb.check_result(out_data);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("bounded_array_list_engine verification failed");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clk);
        end
    end

    // Send one command transaction, with an optional idle burst first
    task automatic send_cmd(input logic [3:0] c, input int p,
                            input logic [31:0] v, input logic [31:0] nv);
        in_item_t it;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        it.cmd = c;
        it.position = p[5:0];
        it.value = v;
        it.new_value = nv;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_command(it);
        sent_count++;
    endtask

    // Pick a value that often matches something already stored
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && sb.shadow_len > 0) return sb.shadow_vals[$urandom_range(0, sb.shadow_len - 1)];
        if (r < 7) return 32'($urandom_range(0, 7)) - 32'd3;
        if (r == 7) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{$urandom_range(0, 1) == 1}}};
        return $urandom;
    endfunction

    function automatic int pick_pos();
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, sb.shadow_len + 1 > 63 ? 63 : sb.shadow_len + 1);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial begin
        logic [3:0] c;
        int wgt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list failures, extremes, every command
        send_cmd(CMD_POP, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0);
        send_cmd(CMD_FIND, 0, 0, 0);
        send_cmd(CMD_REPLACE, 0, 0, 1);
        send_cmd(CMD_DEDUP, 0, 0, 0);
        send_cmd(CMD_SORT, 0, 0, 0);
        send_cmd(CMD_APPEND, 0, 32'h8000_0000, 0);
        send_cmd(CMD_APPEND, 63, 32'h7fff_ffff, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 0, 32'hffff_ffff, 0);
        send_cmd(CMD_INSERT, 3, 32'd5, 0);
        send_cmd(CMD_INSERT, 5, 32'd9, 0);
        send_cmd(CMD_APPEND, 0, 32'hffff_ffff, 0);
        send_cmd(CMD_READ, 63, 0, 0);
        send_cmd(CMD_WRITE, 1, 32'd5, 0);
        send_cmd(CMD_FIND, 0, 32'd5, 0);
        send_cmd(CMD_REPLACE, 0, 32'hffff_ffff, 32'h8000_0000);
        send_cmd(CMD_DEDUP, 0, 0, 0);
        send_cmd(CMD_SORT, 0, 0, 0);
        send_cmd(CMD_DELVAL, 0, 32'd5, 0);
        send_cmd(CMD_DELVAL, 0, 32'd1234, 0);
        send_cmd(CMD_DELAT, 0, 0, 0);
        send_cmd(4'd12, 0, 0, 0);
        send_cmd(4'd15, 63, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(CMD_CLEAR, 0, 0, 0);

        // Hold off until every result is back
        drain();

        // Fill to capacity and overflow
        repeat (DEPTH) send_cmd(CMD_APPEND, 0, pick_value(), 0);
        send_cmd(CMD_APPEND, 0, 1, 0);
        send_cmd(CMD_INSERT, 0, 1, 0);
        send_cmd(CMD_READ, 63, 0, 0);
        send_cmd(CMD_DEDUP, 0, 0, 0);
        send_cmd(CMD_SORT, 0, 0, 0);

        // Random commands weighted toward growth then shrink
        for (int n = 0; n < 1500; n++) begin
            if (n == 1300) begin
                drain();
                quiet_phase = 1'b1;
            end
            wgt = $urandom_range(0, 99);
            if (wgt < 2) c = 4'($urandom_range(12, 15));
            else if (wgt < 3) c = CMD_CLEAR;
            else if (wgt < 5) c = CMD_SORT;
            else if (wgt < 7) c = CMD_DEDUP;
            else if (wgt < 30) c = (n % 400 < 250) ? CMD_APPEND : CMD_POP;
            else c = 4'($urandom_range(0, 8));
            send_cmd(c, pick_pos(), pick_value(), $urandom);
        end

        drain();
        repeat (50) @(posedge clk);
        $display("sent %0d commands, %0d results, %0d reported failure",
                 sent_count, got_count, fail_cmds);
        if (mismatch_count == 0 && sb.pending.size() == 0)
            $display("bounded_array_list_engine verification clean");
        else
            $display("bounded_array_list_engine verification failed");
        $finish;
    end
endmodule
